[design/fcsg_pkg.sv]
`default_nettype none
package fcsg_pkg;
    localparam int FRAME_PERIOD_DEF = 8192;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    localparam logic [15:0] A_NR10 = 16'hFF10;
    localparam logic [15:0] A_NR11 = 16'hFF11;
    localparam logic [15:0] A_NR12 = 16'hFF12;
    localparam logic [15:0] A_NR13 = 16'hFF13;
    localparam logic [15:0] A_NR14 = 16'hFF14;
    localparam logic [15:0] A_NR21 = 16'hFF16;
    localparam logic [15:0] A_NR22 = 16'hFF17;
    localparam logic [15:0] A_NR23 = 16'hFF18;
    localparam logic [15:0] A_NR24 = 16'hFF19;
    localparam logic [15:0] A_NR30 = 16'hFF1A;
    localparam logic [15:0] A_NR31 = 16'hFF1B;
    localparam logic [15:0] A_NR32 = 16'hFF1C;
    localparam logic [15:0] A_NR33 = 16'hFF1D;
    localparam logic [15:0] A_NR34 = 16'hFF1E;
    localparam logic [15:0] A_NR41 = 16'hFF20;
    localparam logic [15:0] A_NR42 = 16'hFF21;
    localparam logic [15:0] A_NR43 = 16'hFF22;
    localparam logic [15:0] A_NR44 = 16'hFF23;
    localparam logic [15:0] A_NR50 = 16'hFF24;
    localparam logic [15:0] A_NR51 = 16'hFF25;
    localparam logic [15:0] A_NR52 = 16'hFF26;
    localparam logic [15:0] A_WAVE_LO = 16'hFF30;
    localparam logic [15:0] A_WAVE_HI = 16'hFF3F;

    localparam logic [10:0] FREQ_MAX = 11'd2047;
endpackage
`default_nettype wire

[design/four_channel_sound_generator.sv]
`default_nettype none
// Four-voice sound unit: two pulse voices (the first with sweep), a wave voice
// over a 16-byte store and an LFSR noise voice, all behind byte registers at
// FF10..FF3F. Each request is a tick, a read or a write; one result per request
// carries read data, voice-on flags and the panned, master-scaled left and right
// mix after that request. The whole update of one request is combinational
// between the input register and the result register, so a request is taken
// every clock unless a full result register is stalled by the master side;
// the result register holds while the master side stalls and the input side
// keeps moving whenever the result slot is free or being emptied.
module four_channel_sound_generator #(
    parameter int FRAME_PERIOD = fcsg_pkg::FRAME_PERIOD_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [1:0] req_type, [17:2] bus_addr, [25:18] write_data, [31:26] zero
    input  wire logic [31:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] read_data, [11:8] channels_on, [21:12] left_mix, [31:22] right_mix
    output logic [31:0]      m_axis_tdata
);
    import fcsg_pkg::*;

    localparam int FCW = $clog2(FRAME_PERIOD + 1);

    // request path
    logic       r_valid;
    logic [1:0] r_kind;
    logic [15:0] r_addr;
    logic [7:0] r_data;
    logic       r_ovalid;
    logic [31:0] r_odata;
    logic [31:0] n_odata;
    logic       work;

    assign work          = r_valid && (!r_ovalid || m_axis_tready);
    assign s_axis_tready = !r_valid || work;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // state
    logic [FCW-1:0] r_fcnt, n_fcnt;
    logic [2:0]  r_fstep, n_fstep;
    logic        r_pwr, n_pwr;
    logic [7:0]  r_mvol, n_mvol, r_pan, n_pan;
    logic [7:0]  r_reg [13];
    logic [7:0]  n_reg [13];
    logic [1:0]  r_pon, n_pon, r_pdac, n_pdac;
    logic [6:0]  r_plen [2];
    logic [6:0]  n_plen [2];
    logic [10:0] r_pfrq [2];
    logic [10:0] n_pfrq [2];
    logic [13:0] r_ptmr [2];
    logic [13:0] n_ptmr [2];
    logic [2:0]  r_pph [2];
    logic [2:0]  n_pph [2];
    logic [3:0]  r_pvol [2];
    logic [3:0]  n_pvol [2];
    logic [3:0]  r_penv [2];
    logic [3:0]  n_penv [2];
    logic [3:0]  r_stmr, n_stmr;
    logic [11:0] r_shf, n_shf;
    logic        r_sact, n_sact, r_neg, n_neg;
    logic        r_won, n_won, r_wdac, n_wdac;
    logic [8:0]  r_wlen, n_wlen;
    logic [10:0] r_wfrq, n_wfrq;
    logic [12:0] r_wtmr, n_wtmr;
    logic [4:0]  r_wpos, n_wpos;
    logic [7:0]  r_wave [16];
    logic        r_non, n_non, r_ndac, n_ndac;
    logic [6:0]  r_nlen, n_nlen;
    logic [21:0] r_ntmr, n_ntmr;
    logic [3:0]  r_nvol, n_nvol, r_nenv, n_nenv;
    logic [14:0] r_nsh, n_nsh;
    logic [7:0]  n_rd;
    logic        wave_we;

    localparam logic [7:0] RAW_INIT [13] = '{8'h80, 8'hBF, 8'hF3, 8'hBF, 8'h3F, 8'h00,
        8'hBF, 8'h7F, 8'h9F, 8'hBF, 8'h00, 8'h00, 8'hBF};
    localparam logic [7:0] DUTY [4] = '{8'h01, 8'h81, 8'h87, 8'h7E};
    localparam int RX_SWP = 0, RX_WDAC = 7, RX_WVOL = 8, RX_WHI = 9;
    localparam int RX_NENV = 10, RX_NPOLY = 11, RX_NHI = 12;

    function automatic logic [21:0] noise_per(input logic [7:0] r);
        logic [21:0] d;
        d = (r[2:0] != 3'd0) ? {15'd0, r[2:0], 4'd0} : 22'd8;
        return d << r[7:4];
    endfunction

    function automatic logic [12:0] sweep_nf(input logic [11:0] sf, input logic [7:0] r);
        logic [11:0] d;
        d = sf >> r[2:0];
        return r[3] ? {1'b0, sf} - {1'b0, d} : {1'b0, sf} + {1'b0, d};
    endfunction

    // next-state logic for one request
    always_comb begin
        logic [12:0] nf;
        logic [7:0]  old, v, env, wb;
        logic [3:0]  smp;
        logic        x, step_clk;
        logic signed [9:0] lvl [4];
        logic signed [9:0] lsum, rsum;
        int c;
        n_fcnt = r_fcnt; n_fstep = r_fstep; n_pwr = r_pwr;
        n_mvol = r_mvol; n_pan = r_pan; n_reg = r_reg;
        n_pon = r_pon; n_pdac = r_pdac; n_plen = r_plen; n_pfrq = r_pfrq;
        n_ptmr = r_ptmr; n_pph = r_pph; n_pvol = r_pvol; n_penv = r_penv;
        n_stmr = r_stmr; n_shf = r_shf; n_sact = r_sact; n_neg = r_neg;
        n_won = r_won; n_wdac = r_wdac; n_wlen = r_wlen; n_wfrq = r_wfrq;
        n_wtmr = r_wtmr; n_wpos = r_wpos;
        n_non = r_non; n_ndac = r_ndac; n_nlen = r_nlen; n_ntmr = r_ntmr;
        n_nvol = r_nvol; n_nenv = r_nenv; n_nsh = r_nsh;
        n_rd = 8'hFF; wave_we = 1'b0;
        v = r_data; old = 8'd0; env = 8'd0; nf = 13'd0; x = 1'b0; step_clk = 1'b0;
        wb = 8'd0; smp = 4'd0; lsum = '0; rsum = '0;
        for (int k = 0; k < 4; k++) lvl[k] = '0;

        if (r_kind == REQ_TICK && r_pwr) begin
            // frame sequencer
            if ({1'b0, r_fcnt} + 1'b1 >= (FCW+1)'(FRAME_PERIOD)) begin
                n_fcnt = '0; step_clk = 1'b1;
            end else begin
                n_fcnt = r_fcnt + 1'b1;
            end
            if (step_clk) begin
                n_fstep = r_fstep + 3'd1;
                if (!r_fstep[0]) begin
                    for (c = 0; c < 2; c++)
                        if (r_reg[3+3*c][6] && r_plen[c] != 0) begin
                            n_plen[c] = r_plen[c] - 7'd1;
                            if (r_plen[c] == 7'd1) n_pon[c] = 1'b0;
                        end
                    if (r_reg[RX_WHI][6] && r_wlen != 0) begin
                        n_wlen = r_wlen - 9'd1;
                        if (r_wlen == 9'd1) n_won = 1'b0;
                    end
                    if (r_reg[RX_NHI][6] && r_nlen != 0) begin
                        n_nlen = r_nlen - 7'd1;
                        if (r_nlen == 7'd1) n_non = 1'b0;
                    end
                    if (r_fstep[1:0] == 2'b10 && r_sact && r_reg[RX_SWP][6:4] != 3'd0) begin
                        if (r_stmr <= 4'd1) begin
                            n_stmr = {1'b0, r_reg[RX_SWP][6:4]};
                            nf = sweep_nf(r_shf, r_reg[RX_SWP]);
                            if (r_reg[RX_SWP][3]) n_neg = 1'b1;
                            if (nf > 13'(FREQ_MAX)) n_pon[0] = 1'b0;
                            else if (r_reg[RX_SWP][2:0] != 3'd0) begin
                                n_pfrq[0] = nf[10:0];
                                n_shf = nf[11:0];
                                if (sweep_nf(nf[11:0], r_reg[RX_SWP]) > 13'(FREQ_MAX))
                                    n_pon[0] = 1'b0;
                            end
                        end else begin
                            n_stmr = r_stmr - 4'd1;
                        end
                    end
                end else if (r_fstep == 3'd7) begin
                    for (c = 0; c < 2; c++) begin
                        env = r_reg[2+3*c];
                        if (env[2:0] != 3'd0) begin
                            if (r_penv[c] <= 4'd1) begin
                                n_penv[c] = {1'b0, env[2:0]};
                                if (env[3]) begin
                                    if (r_pvol[c] < 4'd15) n_pvol[c] = r_pvol[c] + 4'd1;
                                end else if (r_pvol[c] > 4'd0) n_pvol[c] = r_pvol[c] - 4'd1;
                            end else n_penv[c] = r_penv[c] - 4'd1;
                        end
                    end
                    env = r_reg[RX_NENV];
                    if (env[2:0] != 3'd0) begin
                        if (r_nenv <= 4'd1) begin
                            n_nenv = {1'b0, env[2:0]};
                            if (env[3]) begin
                                if (r_nvol < 4'd15) n_nvol = r_nvol + 4'd1;
                            end else if (r_nvol > 4'd0) n_nvol = r_nvol - 4'd1;
                        end else n_nenv = r_nenv - 4'd1;
                    end
                end
            end
            // voice timers (enable seen after the frame step)
            for (c = 0; c < 2; c++)
                if (n_pon[c]) begin
                    if (r_ptmr[c] <= 14'd1) begin
                        n_ptmr[c] = {12'd2048 - {1'b0, n_pfrq[c]}, 2'b00};
                        n_pph[c] = r_pph[c] + 3'd1;
                    end else n_ptmr[c] = r_ptmr[c] - 14'd1;
                end
            if (n_won) begin
                if (r_wtmr <= 13'd1) begin
                    n_wtmr = {12'd2048 - {1'b0, r_wfrq}, 1'b0};
                    n_wpos = r_wpos + 5'd1;
                end else n_wtmr = r_wtmr - 13'd1;
            end
            if (n_non) begin
                if (r_ntmr <= 22'd1) begin
                    n_ntmr = noise_per(r_reg[RX_NPOLY]);
                    x = r_nsh[0] ^ r_nsh[1];
                    n_nsh = {x, r_nsh[14:1]};
                    if (r_reg[RX_NPOLY][3]) n_nsh[6] = x;
                end else n_ntmr = r_ntmr - 22'd1;
            end
        end else if (r_kind == REQ_READ) begin
            if (r_addr >= A_WAVE_LO && r_addr <= A_WAVE_HI)
                n_rd = r_won ? r_wave[r_wpos[4:1]] : r_wave[r_addr[3:0]];
            else begin
                case (r_addr)
                    A_NR10: n_rd = r_reg[0] | 8'h80;
                    A_NR11: n_rd = r_reg[1] | 8'h3F;
                    A_NR12: n_rd = r_reg[2];
                    A_NR14: n_rd = r_reg[3] | 8'hBF;
                    A_NR21: n_rd = r_reg[4] | 8'h3F;
                    A_NR22: n_rd = r_reg[5];
                    A_NR24: n_rd = r_reg[6] | 8'hBF;
                    A_NR30: n_rd = r_reg[RX_WDAC] | 8'h7F;
                    A_NR32: n_rd = r_reg[RX_WVOL] | 8'h9F;
                    A_NR34: n_rd = r_reg[RX_WHI] | 8'hBF;
                    A_NR42: n_rd = r_reg[RX_NENV];
                    A_NR43: n_rd = r_reg[RX_NPOLY];
                    A_NR44: n_rd = r_reg[RX_NHI] | 8'hBF;
                    A_NR50: n_rd = r_mvol;
                    A_NR51: n_rd = r_pan;
                    A_NR52: n_rd = {r_pwr, 3'b111, r_non, r_won, r_pon};
                    default: n_rd = 8'hFF;
                endcase
            end
        end else if (r_kind == REQ_WRITE) begin
            if (r_addr >= A_WAVE_LO && r_addr <= A_WAVE_HI) begin
                wave_we = 1'b1;
            end else if (r_addr == A_NR52) begin
                n_pwr = v[7];
                if (!v[7]) begin
                    for (int k = 0; k < 13; k++) n_reg[k] = 8'd0;
                    n_pon = '0; n_pdac = '0;
                    for (c = 0; c < 2; c++) begin
                        n_plen[c] = '0; n_pfrq[c] = '0; n_ptmr[c] = '0;
                        n_pph[c] = '0; n_pvol[c] = '0; n_penv[c] = '0;
                    end
                    n_stmr = '0; n_shf = '0; n_sact = 1'b0; n_neg = 1'b0;
                    n_won = 1'b0; n_wdac = 1'b0; n_wlen = '0; n_wfrq = '0;
                    n_wtmr = '0; n_wpos = '0;
                    n_non = 1'b0; n_ndac = 1'b0; n_nlen = '0; n_ntmr = '0;
                    n_nvol = '0; n_nenv = '0; n_nsh = '0;
                    n_mvol = 8'd0; n_pan = 8'd0;
                end
            end else if (r_pwr) begin
                case (r_addr)
                    A_NR10: begin
                        n_reg[RX_SWP] = v;
                        if (r_neg && r_reg[RX_SWP][3] && !v[3]) n_pon[0] = 1'b0;
                    end
                    A_NR11, A_NR21: begin
                        c = (r_addr == A_NR11) ? 0 : 1;
                        n_reg[1+3*c] = v;
                        n_plen[c] = 7'd64 - {1'b0, v[5:0]};
                    end
                    A_NR12, A_NR22: begin
                        c = (r_addr == A_NR12) ? 0 : 1;
                        old = r_reg[2+3*c];
                        n_reg[2+3*c] = v;
                        n_pdac[c] = v[7:3] != 5'd0;
                        if (r_pon[c]) begin
                            if (v[3] && !old[3]) n_pvol[c] = r_pvol[c] + 4'd1;
                            else if (old[3] != v[3]) n_pvol[c] = 4'd0 - r_pvol[c];
                        end
                        if (v[7:3] == 5'd0) n_pon[c] = 1'b0;
                    end
                    A_NR13, A_NR23: begin
                        c = (r_addr == A_NR13) ? 0 : 1;
                        n_pfrq[c] = {r_pfrq[c][10:8], v};
                    end
                    A_NR14, A_NR24: begin
                        c = (r_addr == A_NR14) ? 0 : 1;
                        n_reg[3+3*c] = v;
                        n_pfrq[c] = {v[2:0], r_pfrq[c][7:0]};
                        if (v[7]) begin
                            env = r_reg[2+3*c];
                            n_pon[c] = r_pdac[c];
                            if (r_plen[c] == 0)
                                n_plen[c] = (v[6] && !r_fstep[0]) ? 7'd63 : 7'd64;
                            n_ptmr[c] = {12'd2048 - {1'b0, n_pfrq[c]}, 2'b00};
                            n_penv[c] = (env[2:0] != 3'd0) ? {1'b0, env[2:0]} : 4'd8;
                            n_pvol[c] = env[7:4];
                            if (c == 0) begin
                                n_shf = {1'b0, n_pfrq[0]};
                                n_stmr = (r_reg[RX_SWP][6:4] != 3'd0) ?
                                         {1'b0, r_reg[RX_SWP][6:4]} : 4'd8;
                                n_sact = r_reg[RX_SWP][6:0] != 7'd0 &&
                                         (r_reg[RX_SWP][6:4] != 3'd0 ||
                                          r_reg[RX_SWP][2:0] != 3'd0);
                                n_neg = 1'b0;
                                if (r_reg[RX_SWP][2:0] != 3'd0) begin
                                    if (r_reg[RX_SWP][3]) n_neg = 1'b1;
                                    if (sweep_nf({1'b0, n_pfrq[0]}, r_reg[RX_SWP]) >
                                        13'(FREQ_MAX)) n_pon[0] = 1'b0;
                                end
                            end
                        end
                    end
                    A_NR30: begin
                        n_reg[RX_WDAC] = v; n_wdac = v[7];
                        if (!v[7]) n_won = 1'b0;
                    end
                    A_NR31: n_wlen = 9'd256 - {1'b0, v};
                    A_NR32: n_reg[RX_WVOL] = v;
                    A_NR33: n_wfrq = {r_wfrq[10:8], v};
                    A_NR34: begin
                        n_reg[RX_WHI] = v;
                        n_wfrq = {v[2:0], r_wfrq[7:0]};
                        if (v[7]) begin
                            n_won = r_wdac;
                            if (r_wlen == 0)
                                n_wlen = (v[6] && !r_fstep[0]) ? 9'd255 : 9'd256;
                            n_wtmr = {12'd2048 - {1'b0, n_wfrq}, 1'b0};
                            n_wpos = '0;
                        end
                    end
                    A_NR41: n_nlen = 7'd64 - {1'b0, v[5:0]};
                    A_NR42: begin
                        old = r_reg[RX_NENV];
                        n_reg[RX_NENV] = v;
                        n_ndac = v[7:3] != 5'd0;
                        if (r_non) begin
                            if (v[3] && !old[3]) n_nvol = r_nvol + 4'd1;
                            else if (old[3] != v[3]) n_nvol = 4'd0 - r_nvol;
                        end
                        if (v[7:3] == 5'd0) n_non = 1'b0;
                    end
                    A_NR43: n_reg[RX_NPOLY] = v;
                    A_NR44: begin
                        n_reg[RX_NHI] = v;
                        if (v[7]) begin
                            env = r_reg[RX_NENV];
                            n_non = r_ndac;
                            if (r_nlen == 0)
                                n_nlen = (v[6] && !r_fstep[0]) ? 7'd63 : 7'd64;
                            n_ntmr = noise_per(r_reg[RX_NPOLY]);
                            n_nenv = (env[2:0] != 3'd0) ? {1'b0, env[2:0]} : 4'd8;
                            n_nvol = env[7:4];
                            n_nsh = 15'h7FFF;
                        end
                    end
                    A_NR50: n_mvol = v;
                    A_NR51: n_pan = v;
                    default: ;
                endcase
            end
        end

        // voice levels from the new state
        for (c = 0; c < 2; c++)
            if (n_pon[c] && n_pdac[c]) begin
                wb = DUTY[n_reg[1+3*c][7:6]];
                lvl[c] = wb[3'd7 - n_pph[c]] ? $signed({6'd0, n_pvol[c]})
                                             : -$signed({6'd0, n_pvol[c]});
            end
        if (n_won && n_wdac && n_reg[RX_WVOL][6:5] != 2'd0) begin
            wb = wave_we && r_addr[3:0] == n_wpos[4:1] ? r_data : r_wave[n_wpos[4:1]];
            smp = n_wpos[0] ? wb[3:0] : wb[7:4];
            smp = smp >> (n_reg[RX_WVOL][6:5] - 2'd1);
            lvl[2] = $signed({5'd0, smp, 1'b0}) - 10'sd15;
        end
        if (n_non && n_ndac)
            lvl[3] = n_nsh[0] ? -$signed({6'd0, n_nvol}) : $signed({6'd0, n_nvol});
        for (int k = 0; k < 4; k++) begin
            if (n_pan[4+k]) lsum = lsum + lvl[k];
            if (n_pan[k]) rsum = rsum + lvl[k];
        end
        lsum = 10'(lsum * $signed({7'd0, n_mvol[6:4]} + 10'sd1));
        rsum = 10'(rsum * $signed({7'd0, n_mvol[2:0]} + 10'sd1));
        n_odata = {rsum, lsum, n_non, n_won, n_pon, n_rd};
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
        if (s_axis_tready) begin
            r_kind <= s_axis_tdata[1:0];
            r_addr <= s_axis_tdata[17:2];
            r_data <= s_axis_tdata[25:18];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (work) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
        if (work) r_odata <= n_odata;
    end

    // wave store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) r_wave[k] <= 8'd0;
        end else if (work && wave_we) begin
            r_wave[r_addr[3:0]] <= r_data;
        end
    end

    // sound state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcnt <= '0; r_fstep <= '0; r_pwr <= 1'b1;
            r_mvol <= 8'h77; r_pan <= 8'hF3; r_reg <= RAW_INIT;
            r_pon <= '0; r_pdac <= '0;
            for (int k = 0; k < 2; k++) begin
                r_plen[k] <= '0; r_pfrq[k] <= '0; r_ptmr[k] <= '0;
                r_pph[k] <= '0; r_pvol[k] <= '0; r_penv[k] <= '0;
            end
            r_stmr <= '0; r_shf <= '0; r_sact <= 1'b0; r_neg <= 1'b0;
            r_won <= 1'b0; r_wdac <= 1'b0; r_wlen <= '0; r_wfrq <= '0;
            r_wtmr <= '0; r_wpos <= '0;
            r_non <= 1'b0; r_ndac <= 1'b0; r_nlen <= '0; r_ntmr <= '0;
            r_nvol <= '0; r_nenv <= '0; r_nsh <= 15'h7FFF;
        end else if (work) begin
            r_fcnt <= n_fcnt; r_fstep <= n_fstep; r_pwr <= n_pwr;
            r_mvol <= n_mvol; r_pan <= n_pan; r_reg <= n_reg;
            r_pon <= n_pon; r_pdac <= n_pdac; r_plen <= n_plen; r_pfrq <= n_pfrq;
            r_ptmr <= n_ptmr; r_pph <= n_pph; r_pvol <= n_pvol; r_penv <= n_penv;
            r_stmr <= n_stmr; r_shf <= n_shf; r_sact <= n_sact; r_neg <= n_neg;
            r_won <= n_won; r_wdac <= n_wdac; r_wlen <= n_wlen; r_wfrq <= n_wfrq;
            r_wtmr <= n_wtmr; r_wpos <= n_wpos;
            r_non <= n_non; r_ndac <= n_ndac; r_nlen <= n_nlen; r_ntmr <= n_ntmr;
            r_nvol <= n_nvol; r_nenv <= n_nenv; r_nsh <= n_nsh;
        end
    end
endmodule
`default_nettype wire

[bench/four_channel_sound_generator_test.sv]
`default_nettype none
module four_channel_sound_generator_test;
    import fcsg_pkg::*;

    localparam int FRAME_LEN = FRAME_PERIOD_DEF;
    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1400;
    localparam int BURST_EVERY = 160;
    localparam int BURST_TICKS = 40;

    // Raw register slots
    localparam int R_SWP = 0, R_DL1 = 1, R_ENV1 = 2, R_HI1 = 3, R_DL2 = 4, R_ENV2 = 5;
    localparam int R_HI2 = 6, R_WDAC = 7, R_WVOL = 8, R_WHI = 9, R_NENV = 10;
    localparam int R_NPOLY = 11, R_NHI = 12;
    // Voice numbers
    localparam int V_SQ1 = 0, V_SQ2 = 1, V_WAVE = 2, V_NOISE = 3;

    typedef struct {
        logic [1:0]  req;
        logic [15:0] addr;
        logic [7:0]  data;
        bit          calm;
        bit          drain;
    } bus_req_t;

    typedef struct {
        logic [7:0]        rd;
        logic [3:0]        chon;
        logic signed [9:0] left;
        logic signed [9:0] right;
    } mix_out_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [1:0] req_type, [17:2] bus_addr, [25:18] write_data, [31:26] zero
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [7:0] read_data, [11:8] channels_on, [21:12] left_mix, [31:22] right_mix
    logic [31:0] m_axis_tdata;

    four_channel_sound_generator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Shadow copy of the sound unit
    int unsigned fs_count, fs_step;
    bit          pwr;
    logic [7:0]  mvol, pan;
    logic [7:0]  regs [13];
    bit          v_on [4];
    int unsigned v_len [4];
    int unsigned env_vol [4], env_tmr [4];
    bit          sq_dac [2];
    int unsigned sq_freq [2], sq_tmr [2], sq_ph [2];
    int unsigned swp_tmr, swp_shadow;
    bit          swp_act, swp_neg;
    bit          wv_dac;
    int unsigned wv_freq, wv_tmr, wv_pos;
    logic [7:0]  wv_ram [16];
    bit          ns_dac;
    int unsigned ns_tmr;
    logic [14:0] lfsr;

    bus_req_t pend_q[$];
    mix_out_t mix_q[$];
    bus_req_t cur;
    int       gap_left;
    bit       rx_calm;
    int       stall_left;
    int       idle_cycles;
    int       errors;

    function automatic int hi_reg(int v);
        case (v)
            V_SQ1:   return R_HI1;
            V_SQ2:   return R_HI2;
            V_WAVE:  return R_WHI;
            default: return R_NHI;
        endcase
    endfunction

    function automatic int env_reg(int v);
        case (v)
            V_SQ1:   return R_ENV1;
            V_SQ2:   return R_ENV2;
            default: return R_NENV;
        endcase
    endfunction

    function automatic void power_down_clear();
        for (int i = 0; i < 13; i++) regs[i] = 8'h00;
        for (int v = 0; v < 4; v++) begin
            v_on[v] = 0; v_len[v] = 0; env_vol[v] = 0; env_tmr[v] = 0;
        end
        for (int c = 0; c < 2; c++) begin
            sq_dac[c] = 0; sq_freq[c] = 0; sq_tmr[c] = 0; sq_ph[c] = 0;
        end
        swp_tmr = 0; swp_shadow = 0; swp_act = 0; swp_neg = 0;
        wv_dac = 0; wv_freq = 0; wv_tmr = 0; wv_pos = 0;
        ns_dac = 0; ns_tmr = 0; lfsr = 15'h0000;
    endfunction

    function automatic void shadow_reset();
        fs_count = 0; fs_step = 0; pwr = 1; mvol = 8'h77; pan = 8'hF3;
        power_down_clear();
        regs[R_SWP] = 8'h80; regs[R_DL1] = 8'hBF; regs[R_ENV1] = 8'hF3; regs[R_HI1] = 8'hBF;
        regs[R_DL2] = 8'h3F; regs[R_ENV2] = 8'h00; regs[R_HI2] = 8'hBF;
        regs[R_WDAC] = 8'h7F; regs[R_WVOL] = 8'h9F; regs[R_WHI] = 8'hBF;
        regs[R_NENV] = 8'h00; regs[R_NPOLY] = 8'h00; regs[R_NHI] = 8'hBF;
        for (int i = 0; i < 16; i++) wv_ram[i] = 8'h00;
        lfsr = 15'h7FFF;
    endfunction

    function automatic bit len_extra(logic [7:0] hi);
        return hi[6] && (fs_step[0] == 1'b0);
    endfunction

    // New sweep frequency; disable voice 1 on overflow
    function automatic int unsigned sweep_next();
        int unsigned d, nf;
        d = swp_shadow >> regs[R_SWP][2:0];
        if (regs[R_SWP][3]) begin
            nf = swp_shadow - d;
            swp_neg = 1;
        end else begin
            nf = swp_shadow + d;
        end
        if (nf > FREQ_MAX) v_on[V_SQ1] = 0;
        return nf;
    endfunction

    function automatic void sweep_step();
        int unsigned per, nf;
        per = regs[R_SWP][6:4];
        if (!swp_act || per == 0) return;
        if (swp_tmr <= 1) begin
            swp_tmr = per;
            nf = sweep_next();
            if (nf <= FREQ_MAX && regs[R_SWP][2:0] != 0) begin
                sq_freq[0] = nf;
                swp_shadow = nf;
                void'(sweep_next());
            end
        end else begin
            swp_tmr--;
        end
    endfunction

    function automatic void env_step(int v);
        logic [7:0] r;
        r = regs[env_reg(v)];
        if (r[2:0] == 0) return;
        if (env_tmr[v] <= 1) begin
            env_tmr[v] = r[2:0];
            if (r[3]) begin
                if (env_vol[v] < 15) env_vol[v]++;
            end else if (env_vol[v] > 0) begin
                env_vol[v]--;
            end
        end else begin
            env_tmr[v]--;
        end
    endfunction

    // Frame sequencer step: length on even, sweep on 2 and 6, envelope on 7
    function automatic void frame_step_run();
        int unsigned s;
        s = fs_step & 7;
        if (s[0] == 1'b0) begin
            for (int v = 0; v < 4; v++) begin
                if (regs[hi_reg(v)][6] && v_len[v] > 0) begin
                    v_len[v]--;
                    if (v_len[v] == 0) v_on[v] = 0;
                end
            end
            if (s == 2 || s == 6) sweep_step();
        end else if (s == 7) begin
            env_step(V_SQ1);
            env_step(V_SQ2);
            env_step(V_NOISE);
        end
        fs_step = (s + 1) & 7;
    endfunction

    function automatic int unsigned noise_reload();
        int unsigned d;
        d = (regs[R_NPOLY][2:0] != 0) ? regs[R_NPOLY][2:0] * 16 : 8;
        return d << regs[R_NPOLY][7:4];
    endfunction

    function automatic void tick_run();
        logic fb;
        if (!pwr) return;
        fs_count++;
        if (fs_count >= FRAME_LEN) begin
            fs_count -= FRAME_LEN;
            frame_step_run();
        end
        for (int c = 0; c < 2; c++) begin
            if (v_on[c]) begin
                if (sq_tmr[c] <= 1) begin
                    sq_tmr[c] = (2048 - (sq_freq[c] & 2047)) * 4;
                    sq_ph[c] = (sq_ph[c] + 1) & 7;
                end else begin
                    sq_tmr[c]--;
                end
            end
        end
        if (v_on[V_WAVE]) begin
            if (wv_tmr <= 1) begin
                wv_tmr = (2048 - (wv_freq & 2047)) * 2;
                wv_pos = (wv_pos + 1) & 31;
            end else begin
                wv_tmr--;
            end
        end
        if (v_on[V_NOISE]) begin
            if (ns_tmr <= 1) begin
                ns_tmr = noise_reload();
                fb = lfsr[0] ^ lfsr[1];
                lfsr = {fb, lfsr[14:1]};
                if (regs[R_NPOLY][3]) lfsr[6] = fb;
            end else begin
                ns_tmr--;
            end
        end
    endfunction

    // Volume nudge when the envelope register changes on a live voice
    function automatic void env_nudge(int v, logic [7:0] old, logic [7:0] val);
        if (!v_on[v]) return;
        if (val[3] && !old[3]) env_vol[v] = (env_vol[v] + 1) & 15;
        else if (old[3] != val[3]) env_vol[v] = (16 - env_vol[v]) & 15;
    endfunction

    function automatic void sq_trigger(int c);
        logic [7:0] env, r;
        env = regs[env_reg(c)];
        v_on[c] = sq_dac[c];
        if (v_len[c] == 0) begin
            v_len[c] = 64;
            if (len_extra(regs[hi_reg(c)])) v_len[c]--;
        end
        sq_tmr[c] = (2048 - (sq_freq[c] & 2047)) * 4;
        env_tmr[c] = (env[2:0] != 0) ? env[2:0] : 8;
        env_vol[c] = env[7:4];
        if (c == 0) begin
            r = regs[R_SWP];
            swp_shadow = sq_freq[0];
            swp_tmr = (r[6:4] != 0) ? r[6:4] : 8;
            swp_act = (r[6:4] != 0) || (r[2:0] != 0);
            swp_neg = 0;
            if (r[2:0] != 0) void'(sweep_next());
        end
    endfunction

    function automatic void sq_write(int c, int off, logic [7:0] v);
        logic [7:0] old;
        case (off)
            1: begin
                regs[c ? R_DL2 : R_DL1] = v;
                v_len[c] = 64 - v[5:0];
            end
            2: begin
                old = regs[env_reg(c)];
                regs[env_reg(c)] = v;
                sq_dac[c] = (v[7:3] != 0);
                env_nudge(c, old, v);
                if (!sq_dac[c]) v_on[c] = 0;
            end
            3: sq_freq[c] = (sq_freq[c] & 32'h700) | v;
            default: begin
                regs[hi_reg(c)] = v;
                sq_freq[c] = (sq_freq[c] & 32'hFF) | (v[2:0] << 8);
                if (v[7]) sq_trigger(c);
            end
        endcase
    endfunction

    function automatic void reg_write(logic [15:0] a, logic [7:0] v);
        logic [7:0] old;
        if (a >= A_WAVE_LO && a <= A_WAVE_HI) begin
            wv_ram[a[3:0]] = v;
            return;
        end
        if (a == A_NR52) begin
            pwr = v[7];
            if (!pwr) begin
                power_down_clear();
                mvol = 8'h00;
                pan = 8'h00;
            end
            return;
        end
        if (!pwr) return;
        case (a)
            A_NR10: begin
                old = regs[R_SWP];
                regs[R_SWP] = v;
                if (swp_neg && old[3] && !v[3]) v_on[V_SQ1] = 0;
            end
            A_NR11: sq_write(0, 1, v);
            A_NR12: sq_write(0, 2, v);
            A_NR13: sq_write(0, 3, v);
            A_NR14: sq_write(0, 4, v);
            A_NR21: sq_write(1, 1, v);
            A_NR22: sq_write(1, 2, v);
            A_NR23: sq_write(1, 3, v);
            A_NR24: sq_write(1, 4, v);
            A_NR30: begin
                regs[R_WDAC] = v;
                wv_dac = v[7];
                if (!wv_dac) v_on[V_WAVE] = 0;
            end
            A_NR31: v_len[V_WAVE] = 256 - v;
            A_NR32: regs[R_WVOL] = v;
            A_NR33: wv_freq = (wv_freq & 32'h700) | v;
            A_NR34: begin
                regs[R_WHI] = v;
                wv_freq = (wv_freq & 32'hFF) | (v[2:0] << 8);
                if (v[7]) begin
                    v_on[V_WAVE] = wv_dac;
                    if (v_len[V_WAVE] == 0) begin
                        v_len[V_WAVE] = 256;
                        if (len_extra(v)) v_len[V_WAVE]--;
                    end
                    wv_tmr = (2048 - (wv_freq & 2047)) * 2;
                    wv_pos = 0;
                end
            end
            A_NR41: v_len[V_NOISE] = 64 - v[5:0];
            A_NR42: begin
                old = regs[R_NENV];
                regs[R_NENV] = v;
                ns_dac = (v[7:3] != 0);
                env_nudge(V_NOISE, old, v);
                if (!ns_dac) v_on[V_NOISE] = 0;
            end
            A_NR43: regs[R_NPOLY] = v;
            A_NR44: begin
                regs[R_NHI] = v;
                if (v[7]) begin
                    v_on[V_NOISE] = ns_dac;
                    if (v_len[V_NOISE] == 0) begin
                        v_len[V_NOISE] = 64;
                        if (len_extra(v)) v_len[V_NOISE]--;
                    end
                    ns_tmr = noise_reload();
                    env_tmr[V_NOISE] = (regs[R_NENV][2:0] != 0) ? regs[R_NENV][2:0] : 8;
                    env_vol[V_NOISE] = regs[R_NENV][7:4];
                    lfsr = 15'h7FFF;
                end
            end
            A_NR50: mvol = v;
            A_NR51: pan = v;
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] reg_read(logic [15:0] a);
        if (a >= A_WAVE_LO && a <= A_WAVE_HI)
            return v_on[V_WAVE] ? wv_ram[(wv_pos >> 1) & 15] : wv_ram[a[3:0]];
        case (a)
            A_NR10:  return regs[R_SWP] | 8'h80;
            A_NR11:  return regs[R_DL1] | 8'h3F;
            A_NR12:  return regs[R_ENV1];
            A_NR14:  return regs[R_HI1] | 8'hBF;
            A_NR21:  return regs[R_DL2] | 8'h3F;
            A_NR22:  return regs[R_ENV2];
            A_NR24:  return regs[R_HI2] | 8'hBF;
            A_NR30:  return regs[R_WDAC] | 8'h7F;
            A_NR32:  return regs[R_WVOL] | 8'h9F;
            A_NR34:  return regs[R_WHI] | 8'hBF;
            A_NR42:  return regs[R_NENV];
            A_NR43:  return regs[R_NPOLY];
            A_NR44:  return regs[R_NHI] | 8'hBF;
            A_NR50:  return mvol;
            A_NR51:  return pan;
            A_NR52:  return {pwr, 3'b111, v_on[V_NOISE], v_on[V_WAVE], v_on[V_SQ2], v_on[V_SQ1]};
            default: return 8'hFF;
        endcase
    endfunction

    // Apply one request to the shadow state and return the mixer output after it
    function automatic mix_out_t sound_step(bus_req_t r);
        mix_out_t o;
        int lvl [4];
        int lsum, rsum;
        int unsigned code, s;
        logic [7:0] duty, b;
        o.rd = 8'hFF;
        case (r.req)
            REQ_TICK:  tick_run();
            REQ_READ:  o.rd = reg_read(r.addr);
            REQ_WRITE: reg_write(r.addr, r.data);
            default:   ;
        endcase
        for (int v = 0; v < 4; v++) lvl[v] = 0;
        for (int c = 0; c < 2; c++) begin
            if (v_on[c] && sq_dac[c]) begin
                case (regs[c ? R_DL2 : R_DL1][7:6])
                    2'd0:    duty = 8'h01;
                    2'd1:    duty = 8'h81;
                    2'd2:    duty = 8'h87;
                    default: duty = 8'h7E;
                endcase
                lvl[c] = duty[7 - sq_ph[c]] ? int'(env_vol[c]) : -int'(env_vol[c]);
            end
        end
        if (v_on[V_WAVE] && wv_dac) begin
            code = regs[R_WVOL][6:5];
            if (code != 0) begin
                b = wv_ram[(wv_pos >> 1) & 15];
                s = wv_pos[0] ? b[3:0] : b[7:4];
                s = s >> (code - 1);
                lvl[V_WAVE] = 2 * int'(s) - 15;
            end
        end
        if (v_on[V_NOISE] && ns_dac)
            lvl[V_NOISE] = lfsr[0] ? -int'(env_vol[V_NOISE]) : int'(env_vol[V_NOISE]);
        lsum = 0;
        rsum = 0;
        for (int v = 0; v < 4; v++) begin
            if (pan[4 + v]) lsum += lvl[v];
            if (pan[v]) rsum += lvl[v];
        end
        lsum *= int'(mvol[6:4]) + 1;
        rsum *= int'(mvol[2:0]) + 1;
        o.chon = {v_on[V_NOISE], v_on[V_WAVE], v_on[V_SQ2], v_on[V_SQ1]};
        o.left = lsum[9:0];
        o.right = rsum[9:0];
        return o;
    endfunction

    function automatic void add_req(logic [1:0] req, logic [15:0] addr, logic [7:0] data,
                                    bit calm, bit drain);
        bus_req_t r;
        r.req = req; r.addr = addr; r.data = data; r.calm = calm; r.drain = drain;
        pend_q.push_back(r);
    endfunction

    function automatic int draw_gap(bit calm);
        if (calm || $urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 18);
    endfunction

    // Request driver
    always @(posedge i_clk) begin : drive_requests
        bit nv;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= 32'd0;
            gap_left = 0;
        end else begin
            nv = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                mix_q.push_back(sound_step(cur));
                nv = 0;
                gap_left = draw_gap(cur.calm);
            end
            if (!nv) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pend_q.size() > 0 && (!pend_q[0].drain || mix_q.size() == 0)) begin
                    cur = pend_q.pop_front();
                    rx_calm = cur.calm;
                    s_axis_tdata <= {6'd0, cur.data, cur.addr, cur.req};
                    nv = 1;
                end
            end
            s_axis_tvalid <= nv;
        end
    end

    // Result checker with random backpressure
    always @(posedge i_clk) begin : check_results
        mix_out_t e;
        bit rdy;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end else begin
            rdy = m_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                if (mix_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_axis_tdata);
                    errors++;
                end else begin
                    e = mix_q.pop_front();
                    if (m_axis_tdata[7:0] !== e.rd) begin
                        $display("%0t: read_data expected %h actual %h",
                                 $time, e.rd, m_axis_tdata[7:0]);
                        errors++;
                    end
                    if (m_axis_tdata[11:8] !== e.chon) begin
                        $display("%0t: channels_on expected %h actual %h",
                                 $time, e.chon, m_axis_tdata[11:8]);
                        errors++;
                    end
                    if (m_axis_tdata[21:12] !== e.left) begin
                        $display("%0t: left_mix expected %0d actual %0d",
                                 $time, e.left, $signed(m_axis_tdata[21:12]));
                        errors++;
                    end
                    if (m_axis_tdata[31:22] !== e.right) begin
                        $display("%0t: right_mix expected %0d actual %0d",
                                 $time, e.right, $signed(m_axis_tdata[31:22]));
                        errors++;
                    end
                end
                stall_left = draw_gap(rx_calm);
            end
            if (stall_left > 0) begin
                stall_left--;
                rdy = 0;
            end else begin
                rdy = 1;
            end
            m_axis_tready <= rdy;
        end
    end

    // Hang detector
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic void add_random();
        logic [1:0]  req;
        logic [15:0] addr;
        logic [7:0]  data;
        int k;
        k = $urandom_range(0, 99);
        req = (k < 45) ? REQ_TICK : (k < 60) ? REQ_READ : (k < 97) ? REQ_WRITE : 2'd3;
        k = $urandom_range(0, 9);
        if (k == 0) addr = $urandom;
        else if (k < 3) addr = A_WAVE_LO + $urandom_range(0, 15);
        else addr = A_NR10 + $urandom_range(0, 22);
        data = $urandom;
        // keep power mostly on
        if (addr == A_NR52 && $urandom_range(0, 7) != 0) data[7] = 1'b1;
        add_req(req, addr, data, 0, 0);
    endfunction

    // Arm every voice with length enabled, then run ticks back to back
    function automatic void add_burst();
        add_req(REQ_WRITE, A_NR52, 8'h80, 1, 0);
        add_req(REQ_WRITE, A_NR10, $urandom, 1, 0);
        add_req(REQ_WRITE, A_NR11, $urandom, 1, 0);
        add_req(REQ_WRITE, A_NR12, 8'hF0 | $urandom_range(0, 15), 1, 0);
        add_req(REQ_WRITE, A_NR14, 8'hC0 | $urandom_range(0, 7), 1, 0);
        add_req(REQ_WRITE, A_NR22, 8'h08 | $urandom, 1, 0);
        add_req(REQ_WRITE, A_NR24, 8'hC0 | $urandom_range(0, 7), 1, 0);
        add_req(REQ_WRITE, A_NR30, 8'h80, 1, 0);
        add_req(REQ_WRITE, A_NR31, $urandom_range(200, 255), 1, 0);
        add_req(REQ_WRITE, A_NR34, 8'hC0 | $urandom_range(0, 7), 1, 0);
        add_req(REQ_WRITE, A_NR42, 8'h08 | $urandom, 1, 0);
        add_req(REQ_WRITE, A_NR44, 8'hC0, 1, 0);
        for (int i = 0; i < BURST_TICKS; i++) add_req(REQ_TICK, 16'h0000, 8'h00, 1, 0);
    endfunction

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 32'd0;
        m_axis_tready = 1'b0;
        errors = 0;
        idle_cycles = 0;
        rx_calm = 0;
        shadow_reset();

        // Directed: reset values, odd addresses, wave store, each voice, quirks, power
        add_req(REQ_READ, A_NR52, 8'h00, 0, 0);
        add_req(REQ_READ, 16'h0000, 8'hFF, 0, 0);
        add_req(REQ_READ, 16'hFFFF, 8'h00, 0, 0);
        add_req(2'd3, A_NR52, 8'h00, 0, 0);
        add_req(REQ_WRITE, A_WAVE_LO, 8'hFF, 0, 0);
        add_req(REQ_WRITE, A_WAVE_HI, 8'h00, 0, 0);
        add_req(REQ_READ, A_WAVE_LO, 8'h00, 0, 0);
        add_req(REQ_WRITE, A_NR50, 8'hFF, 0, 0);
        add_req(REQ_WRITE, A_NR51, 8'hFF, 0, 0);
        add_req(REQ_WRITE, A_NR10, 8'h19, 0, 0);
        add_req(REQ_WRITE, A_NR11, 8'hC0, 0, 0);
        add_req(REQ_WRITE, A_NR12, 8'hF8, 0, 0);
        add_req(REQ_WRITE, A_NR13, 8'hFF, 0, 0);
        add_req(REQ_WRITE, A_NR14, 8'hC7, 0, 0);
        add_req(REQ_WRITE, A_NR10, 8'h11, 0, 0);
        add_req(REQ_WRITE, A_NR22, 8'hF0, 0, 1);
        add_req(REQ_WRITE, A_NR24, 8'h80, 0, 0);
        add_req(REQ_WRITE, A_NR22, 8'hF8, 0, 0);
        add_req(REQ_WRITE, A_NR30, 8'h80, 0, 0);
        add_req(REQ_WRITE, A_NR32, 8'h20, 0, 0);
        add_req(REQ_WRITE, A_NR34, 8'hC7, 0, 0);
        for (int i = 0; i < 4; i++) add_req(REQ_TICK, 16'h0000, 8'h00, 0, 0);
        add_req(REQ_READ, A_WAVE_HI, 8'h00, 0, 0);
        add_req(REQ_WRITE, A_NR42, 8'hF7, 0, 0);
        add_req(REQ_WRITE, A_NR43, 8'h08, 0, 0);
        add_req(REQ_WRITE, A_NR44, 8'hC0, 0, 0);
        for (int i = 0; i < 20; i++) add_req(REQ_TICK, 16'h0000, 8'h00, 1, 0);
        add_req(REQ_WRITE, A_NR52, 8'h00, 0, 0);
        add_req(REQ_WRITE, A_NR12, 8'hF0, 0, 0);
        add_req(REQ_TICK, 16'h0000, 8'h00, 0, 0);
        add_req(REQ_READ, A_NR50, 8'h00, 0, 0);
        add_req(REQ_WRITE, A_NR52, 8'h80, 0, 0);

        // Random traffic, with runs of back-to-back ticks now and then
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % BURST_EVERY == BURST_EVERY - 1) add_burst();
            if (i == RANDOM_ITEMS / 2) add_req(REQ_READ, A_NR52, 8'h00, 0, 1);
            else add_random();
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (pend_q.size() != 0 || s_axis_tvalid || mix_q.size() != 0);
        repeat (20) @(posedge i_clk);
        if (errors == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
design/fcsg_pkg.sv
design/four_channel_sound_generator.sv
bench/four_channel_sound_generator_test.sv
